### rtl/sssm_pkg.sv
package sssm_pkg;

  localparam int unsigned PENDING_DEPTH_DEF = 16;
  localparam int unsigned KEY_WIDTH_DEF     = 64;
  localparam int unsigned KEY_PORT_W        = 64;

  // set_mode codes
  localparam logic [2:0] MODE_UNION = 3'd0;
  localparam logic [2:0] MODE_SYMD  = 3'd1;
  localparam logic [2:0] MODE_MERGE = 3'd2;
  localparam logic [2:0] MODE_DIFF  = 3'd3;
  localparam logic [2:0] MODE_INTER = 3'd4;

  // config register indexes
  localparam logic CFG_SET_MODE    = 1'b0;
  localparam logic CFG_KEYS_SIGNED = 1'b1;

  // marker codes
  localparam logic [1:0] MARK_ELEM = 2'd0;
  localparam logic [1:0] MARK_LAST = 2'd1;

  // result_kind codes
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  // decision side
  localparam logic [1:0] SIDE_A    = 2'd0;
  localparam logic [1:0] SIDE_PAIR = 2'd2;

endpackage

### rtl/sssm_pend_mem.sv
module sssm_pend_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sorted_stream_set_merge.sv
// Channel | Dir | Signals
// in      | in  | in_valid_i / in_ready_o, source_side_i, key_value_i, marker_i
// out     | out | out_valid_o / out_ready_i, result_key_o, result_kind_o, final_result_o
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (no handshake)
//
// One input beat at a time. An element passes accept, memory read, compare, end check
// and flush, plus a read and compare per passed head of the other side. An end without
// element passes accept, end check, last check and flush; an element with end mark also
// passes the last check. Draining the store on an end mark adds a check plus a read and
// decision per drained key. A merge pair adds a state. Every emitted result stalls on a
// full output side. Reset empties the store at once (count and pointers cleared).
module sorted_stream_set_merge
  import sssm_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH     = KEY_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [2:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  source_side_i,
  input  logic [KEY_PORT_W-1:0] key_value_i,
  input  logic [1:0]            marker_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KEY_PORT_W-1:0] result_key_o,
  output logic [1:0]            result_kind_o,
  output logic                  final_result_o
);

  localparam int unsigned D   = PENDING_DEPTH;
  localparam int unsigned AW  = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW  = $clog2(D + 1);
  localparam int unsigned MAXR = D + 1;
  localparam int unsigned NW  = $clog2(MAXR + 1);
  localparam int unsigned KW  = KEY_WIDTH;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TWAIT = 4'd1;
  localparam logic [3:0] ST_TCMP  = 4'd2;
  localparam logic [3:0] ST_DUP   = 4'd3;
  localparam logic [3:0] ST_ENDCK = 4'd4;
  localparam logic [3:0] ST_DWAIT = 4'd5;
  localparam logic [3:0] ST_DRAIN = 4'd6;
  localparam logic [3:0] ST_LAST  = 4'd7;
  localparam logic [3:0] ST_FLUSH = 4'd8;

  logic [3:0]    st_q, ret_q;
  logic [2:0]    mode_q;
  logic          sgn_q;
  logic          s_q;
  logic [KW-1:0] k_q, dup_key_q;
  logic [1:0]    mk_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] head_q, tail_q;
  logic          pside_q;
  logic [1:0]    ended_q;
  logic [KW-1:0] lhk_q;
  logic          lhv_q;
  logic [NW-1:0] n_q;
  logic          fin_q;
  logic          hold_v_q;
  logic [KW-1:0] hold_key_q;
  logic [1:0]    hold_kind_q;
  logic          out_v_q;
  logic [KW-1:0] out_key_q;
  logic [1:0]    out_kind_q;
  logic          out_fin_q;

  logic [KW-1:0] rd_key;
  logic          mem_we;
  logic          out_free, can_put;

  sssm_pend_mem #(.DEPTH(D), .WIDTH(KW), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (k_q),
    .raddr_i (head_q),
    .rdata_o (rd_key)
  );

  assign out_free = !out_v_q || out_ready_i;
  assign can_put  = !hold_v_q || out_free;

  // key compare, sign bit flipped for two's complement order
  logic [KW-1:0] ca, cb;
  logic          h_lt_k, k_lt_h;
  always_comb begin
    ca = rd_key;
    cb = k_q;
    if (sgn_q) begin
      ca[KW-1] = ~ca[KW-1];
      cb[KW-1] = ~cb[KW-1];
    end
    h_lt_k = ca < cb;
    k_lt_h = cb < ca;
  end

  logic opp;
  assign opp = (cnt_q != '0) && (pside_q != s_q);

  // step control
  logic          d_go;
  logic [KW-1:0] d_key;
  logic [1:0]    d_side;
  logic          pop, push;
  logic          p_raw;
  logic [KW-1:0] p_key;
  logic [1:0]    p_kind;
  logic [3:0]    nxt;

  // decision rules
  logic [2:0] mode_eff;
  logic       dup_hit;
  logic [1:0] dec_n;
  logic       dec_lh;
  always_comb begin
    mode_eff = (mode_q > MODE_INTER) ? MODE_UNION : mode_q;
    dup_hit  = lhv_q && (lhk_q == d_key);
    dec_lh   = 1'b0;
    unique case (mode_eff)
      MODE_MERGE: dec_n = (d_side == SIDE_PAIR) ? 2'd2 : 2'd1;
      MODE_DIFF:  dec_n = (d_side == SIDE_A) ? 2'd1 : 2'd0;
      MODE_INTER: dec_n = (d_side == SIDE_PAIR) ? 2'd1 : 2'd0;
      default: begin
        dec_lh = !dup_hit;
        dec_n  = (!dup_hit && (mode_eff == MODE_UNION || d_side != SIDE_PAIR)) ? 2'd1 : 2'd0;
      end
    endcase
  end

  always_comb begin
    d_go   = 1'b0;
    d_key  = k_q;
    d_side = {1'b0, s_q};
    pop    = 1'b0;
    push   = 1'b0;
    p_raw  = 1'b0;
    p_key  = k_q;
    p_kind = KIND_KEY;
    nxt    = st_q;
    unique case (st_q)
      ST_TWAIT: nxt = ST_TCMP;
      ST_TCMP: begin
        if (can_put) begin
          nxt = ST_ENDCK;
          if (opp) begin
            d_go = 1'b1;
            if (h_lt_k) begin
              d_key  = rd_key;
              d_side = {1'b0, ~s_q};
              pop    = 1'b1;
              nxt    = ST_TWAIT;
            end else if (!k_lt_h) begin
              d_side = SIDE_PAIR;
              pop    = 1'b1;
            end
          end else if (ended_q[~s_q]) begin
            d_go = 1'b1;
          end else if (cnt_q < CW'(D)) begin
            push = 1'b1;
          end else begin
            p_raw  = 1'b1;
            p_kind = KIND_DROP;
          end
        end
      end
      ST_DUP: begin
        if (can_put) begin
          p_raw = 1'b1;
          p_key = dup_key_q;
          nxt   = ret_q;
        end
      end
      ST_ENDCK: begin
        if (mk_q == MARK_ELEM) nxt = ST_FLUSH;
        else if (pside_q != s_q && cnt_q != '0) nxt = ST_DWAIT;
        else nxt = ST_LAST;
      end
      ST_DWAIT: nxt = (cnt_q == '0) ? ST_LAST : ST_DRAIN;
      ST_DRAIN: begin
        if (can_put) begin
          d_go   = 1'b1;
          d_key  = rd_key;
          d_side = {1'b0, ~s_q};
          pop    = 1'b1;
          nxt    = ST_DWAIT;
        end
      end
      ST_LAST: begin
        if (ended_q == 2'b11 && n_q == '0) begin
          if (can_put) begin
            p_raw  = 1'b1;
            p_key  = '0;
            p_kind = KIND_EMPTY;
            nxt    = ST_FLUSH;
          end
        end else begin
          nxt = ST_FLUSH;
        end
      end
      default: ;
    endcase
    if (d_go && dec_n != 2'd0) begin
      p_raw = 1'b1;
      p_key = d_key;
    end
  end

  logic p_en;
  logic out_load;
  assign p_en     = p_raw && (n_q < NW'(MAXR));
  assign mem_we   = push;
  // held beat moves to the output register
  assign out_load = hold_v_q && ((st_q == ST_FLUSH) ? out_free : p_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ret_q    <= ST_IDLE;
      mode_q   <= MODE_UNION;
      sgn_q    <= 1'b0;
      cnt_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      pside_q  <= 1'b0;
      ended_q  <= 2'b00;
      lhk_q    <= '0;
      lhv_q    <= 1'b0;
      n_q      <= '0;
      fin_q    <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      s_q      <= 1'b0;
      mk_q     <= MARK_ELEM;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SET_MODE:    mode_q <= cfg_data_i;
          CFG_KEYS_SIGNED: sgn_q  <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_load) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;

      if (st_q == ST_IDLE) begin
        if (in_valid_i) begin
          s_q  <= source_side_i;
          k_q  <= key_value_i[KW-1:0];
          mk_q <= marker_i;
          n_q  <= '0;
          if (ended_q[source_side_i]) st_q <= ST_IDLE;
          else if (marker_i[1]) st_q <= ST_ENDCK;
          else st_q <= ST_TWAIT;
        end
      end else if (st_q == ST_FLUSH) begin
        if (!hold_v_q) begin
          fin_q <= 1'b0;
          st_q  <= ST_IDLE;
        end else if (out_free) begin
          out_key_q  <= hold_key_q;
          out_kind_q <= hold_kind_q;
          out_fin_q  <= fin_q;
          hold_v_q   <= 1'b0;
          fin_q      <= 1'b0;
          st_q       <= ST_IDLE;
        end
      end else begin
        if (d_go && dec_n == 2'd2) begin
          dup_key_q <= d_key;
          ret_q     <= nxt;
          st_q      <= ST_DUP;
        end else begin
          st_q <= nxt;
        end
        if (d_go && dec_lh) begin
          lhk_q <= d_key;
          lhv_q <= 1'b1;
        end
        if (pop) begin
          head_q <= (head_q == AW'(D - 1)) ? '0 : head_q + AW'(1);
          cnt_q  <= cnt_q - CW'(1);
        end
        if (push) begin
          tail_q  <= (tail_q == AW'(D - 1)) ? '0 : tail_q + AW'(1);
          cnt_q   <= cnt_q + CW'(1);
          pside_q <= s_q;
        end
        if (st_q == ST_ENDCK && mk_q != MARK_ELEM) begin
          ended_q[s_q] <= 1'b1;
        end
        if (p_en) begin
          n_q         <= n_q + NW'(1);
          hold_v_q    <= 1'b1;
          hold_key_q  <= p_key;
          hold_kind_q <= p_kind;
          if (hold_v_q) begin
            out_key_q  <= hold_key_q;
            out_kind_q <= hold_kind_q;
            out_fin_q  <= 1'b0;
          end
        end
        // operation complete: both streams ended
        if (st_q == ST_LAST && nxt == ST_FLUSH && ended_q == 2'b11) begin
          fin_q   <= 1'b1;
          cnt_q   <= '0;
          head_q  <= '0;
          tail_q  <= '0;
          pside_q <= 1'b0;
          ended_q <= 2'b00;
          lhv_q   <= 1'b0;
        end
      end
    end
  end

  assign in_ready_o     = (st_q == ST_IDLE);
  assign out_valid_o    = out_v_q;
  assign result_key_o   = KEY_PORT_W'(out_key_q);
  assign result_kind_o  = out_kind_q;
  assign final_result_o = out_fin_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sssm_pkg::*;

  localparam int unsigned STORE_DEPTH = PENDING_DEPTH_DEF;
  localparam int unsigned WDOG_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYC  = 60;
  localparam int unsigned LONG_HOLD   = 400;

  typedef struct packed {
    logic [63:0] key;
    logic [1:0]  kind;
    logic        fin;
  } res_t;

  typedef struct packed {
    logic        side;
    logic [63:0] key;
    logic [1:0]  mk;
  } beat_t;

  typedef struct packed {
    logic        side;
    logic [63:0] key;
    logic [1:0]  mk;
    logic        typed;
    logic [63:0] ekey;
    logic [1:0]  ekind;
    logic        efin;
  } row_t;

  localparam logic [1:0] MARK_END  = 2'd2;
  localparam logic [1:0] MARK_ODD  = 2'd3;
  localparam logic [63:0] K_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] K_MSB  = 64'h8000_0000_0000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [2:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic source_side_i = 1'b0;
  logic [KEY_PORT_W-1:0] key_value_i = '0;
  logic [1:0] marker_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [KEY_PORT_W-1:0] result_key_o;
  logic [1:0] result_kind_o;
  logic final_result_o;

  sorted_stream_set_merge u_dut (.*);

  always #5 clk_i = ~clk_i;

  // merge predictor state
  logic [2:0]  mode_r;
  logic        signed_r;
  logic [63:0] pend_q[$];
  logic        pend_side;
  logic [1:0]  ended;
  logic [63:0] last_key;
  logic        last_vld;

  res_t want_q[$];
  res_t step_q[$];
  int   errors = 0;
  bit   no_idle = 0;
  bit   stall_req = 0;
  int   hold_cnt = 0;
  int   stall_cnt = 0;
  int   idle_cnt = 0;

  function automatic bit key_lt(logic [63:0] a, logic [63:0] b);
    if (signed_r) return $signed(a) < $signed(b);
    return a < b;
  endfunction

  function automatic void emit(logic [63:0] k, logic [1:0] kind);
    res_t r;
    r.key = k;
    r.kind = kind;
    r.fin = 1'b0;
    if (step_q.size() < STORE_DEPTH + 1) step_q = {step_q, r};
  endfunction

  // side: A or B alone, SIDE_PAIR equal pair
  function automatic void decide(logic [63:0] k, logic [1:0] side);
    case (mode_r)
      MODE_MERGE: begin
        emit(k, KIND_KEY);
        if (side == SIDE_PAIR) emit(k, KIND_KEY);
      end
      MODE_DIFF: if (side == SIDE_A) emit(k, KIND_KEY);
      MODE_INTER: if (side == SIDE_PAIR) emit(k, KIND_KEY);
      default: begin
        if (!(last_vld && last_key == k)) begin
          last_key = k;
          last_vld = 1'b1;
          if (mode_r == MODE_SYMD ? side != SIDE_PAIR : 1'b1) emit(k, KIND_KEY);
        end
      end
    endcase
  endfunction

  function automatic void take_key(logic s, logic [63:0] k);
    logic [63:0] h;
    forever begin
      if (pend_q.size() > 0 && pend_side != s) begin
        h = pend_q[0];
        if (key_lt(h, k)) begin
          decide(h, {1'b0, ~s});
          void'(pend_q.pop_front());
          continue;
        end
        if (key_lt(k, h)) decide(k, {1'b0, s});
        else begin
          decide(k, SIDE_PAIR);
          void'(pend_q.pop_front());
        end
        return;
      end
      if (ended[~s]) decide(k, {1'b0, s});
      else if (pend_q.size() < STORE_DEPTH) begin
        pend_q = {pend_q, k};
        pend_side = s;
      end else emit(k, KIND_DROP);
      return;
    end
  endfunction

  // fills step_q with the results of one accepted beat
  function automatic void merge_step(beat_t b);
    step_q.delete();
    if (ended[b.side]) return;
    if (b.mk == MARK_ELEM || b.mk == MARK_LAST) take_key(b.side, b.key);
    if (b.mk != MARK_ELEM) begin
      ended[b.side] = 1'b1;
      if (pend_side != b.side) begin
        while (pend_q.size() > 0) begin
          decide(pend_q[0], {1'b0, ~b.side});
          void'(pend_q.pop_front());
        end
      end
      if (ended == 2'b11) begin
        if (step_q.size() == 0) emit('0, KIND_EMPTY);
        step_q[step_q.size() - 1].fin = 1'b1;
        pend_q.delete();
        pend_side = 1'b0;
        ended = '0;
        last_vld = 1'b0;
      end
    end
  endfunction

  task automatic report(string what, res_t exp_r, res_t act_r);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): exp key=%h kind=%0d fin=%0d, got key=%h kind=%0d fin=%0d",
               what, exp_r.key, exp_r.kind, exp_r.fin, act_r.key, act_r.kind, act_r.fin);
  endtask

  // result monitor
  always @(posedge clk_i) begin
    res_t got;
    got = '{key: result_key_o, kind: result_kind_o, fin: final_result_o};
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (want_q.size() == 0) report("unexpected beat", '0, got);
      else if (want_q[0] !== got) report("result beat", want_q[0], got);
      if (want_q.size() > 0) void'(want_q.pop_front());
    end
  end

  // receiver: random backpressure plus one long hold on request
  always @(negedge clk_i) begin
    if (stall_req) begin
      out_ready_i = 1'b0;
      stall_cnt++;
      if (stall_cnt >= LONG_HOLD) begin
        stall_req = 0;
        stall_cnt = 0;
      end
    end else if (hold_cnt > 0) begin
      out_ready_i = 1'b0;
      hold_cnt--;
    end else begin
      out_ready_i = 1'b1;
      if (!no_idle) begin
        case ($urandom_range(0, 99)) inside
          [0:14]:  hold_cnt = $urandom_range(1, 3);
          [15:17]: hold_cnt = $urandom_range(10, 40);
          default: hold_cnt = 0;
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt = 0;
    else if (rst_ni) idle_cnt++;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_beat(beat_t b);
    int gap;
    gap = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 99)) inside
        [0:59]:  gap = 0;
        [60:89]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(10, 40);
      endcase
    end
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    source_side_i = b.side;
    key_value_i = b.key;
    marker_i = b.mk;
    do @(posedge clk_i); while (!in_ready_o);
    merge_step(b);
    want_q = {want_q, step_q};
    @(negedge clk_i);
  endtask

  task automatic drain_block();
    in_valid_i = 1'b0;
    wait (want_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [2:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_SET_MODE) mode_r = val;
    else signed_r = val[0];
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 19)) inside
      [0:13]: return 64'($urandom_range(0, 12));
      14:     return K_ONES - 64'($urandom_range(0, 2));
      15:     return K_MSB + 64'($urandom_range(0, 2));
      16:     return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one operation: two streams with random content, sorted unless noise is drawn, randomly interleaved unless burst
  task automatic run_op(bit burst);
    logic [63:0] sa[$], sb[$], t;
    bit noise, ends_sep_a, ends_sep_b, pick_a;
    int na, nb, j;
    na = burst ? $urandom_range(17, 20) : $urandom_range(0, 6);
    nb = burst ? $urandom_range(0, 3) : $urandom_range(0, 6);
    noise = ($urandom_range(0, 9) == 0);
    repeat (na) sa = {sa, pick_key()};
    repeat (nb) sb = {sb, pick_key()};
    if (!noise) begin
      for (int i = 1; i < sa.size(); i++)
        for (j = i; j > 0 && key_lt(sa[j], sa[j-1]); j--) begin
          t = sa[j]; sa[j] = sa[j-1]; sa[j-1] = t;
        end
      for (int i = 1; i < sb.size(); i++)
        for (j = i; j > 0 && key_lt(sb[j], sb[j-1]); j--) begin
          t = sb[j]; sb[j] = sb[j-1]; sb[j-1] = t;
        end
    end
    ends_sep_a = (na == 0) || $urandom_range(0, 2) == 0;
    ends_sep_b = (nb == 0) || $urandom_range(0, 2) == 0;
    // a stream is done once its end is sent; track with sizes and flags
    while (sa.size() > 0 || sb.size() > 0 || ends_sep_a || ends_sep_b) begin
      if (burst) pick_a = (sa.size() > 0 || ends_sep_a);
      else if (!(sa.size() > 0 || ends_sep_a)) pick_a = 0;
      else if (!(sb.size() > 0 || ends_sep_b)) pick_a = 1;
      else pick_a = $urandom_range(0, 1);
      if (pick_a) begin
        if (sa.size() > 0) begin
          t = sa.pop_front();
          send_beat('{side: 1'b0, key: t,
                      mk: (sa.size() == 0 && !ends_sep_a) ? MARK_LAST : MARK_ELEM});
        end else begin
          send_beat('{side: 1'b0, key: {$urandom, $urandom},
                      mk: $urandom_range(0, 1) ? MARK_END : MARK_ODD});
          ends_sep_a = 0;
        end
        // stray beat on an ended stream now and then
        if (sa.size() == 0 && !ends_sep_a && (sb.size() > 0 || ends_sep_b) &&
            $urandom_range(0, 7) == 0)
          send_beat('{side: 1'b0, key: pick_key(), mk: 2'($urandom_range(0, 3))});
      end else begin
        if (sb.size() > 0) begin
          t = sb.pop_front();
          send_beat('{side: 1'b1, key: t,
                      mk: (sb.size() == 0 && !ends_sep_b) ? MARK_LAST : MARK_ELEM});
        end else begin
          send_beat('{side: 1'b1, key: {$urandom, $urandom},
                      mk: $urandom_range(0, 1) ? MARK_END : MARK_ODD});
          ends_sep_b = 0;
        end
      end
    end
  endtask

  row_t dir_tab[] = '{
    '{1'b0, 64'd0, MARK_END,  1'b0, 64'd0, KIND_KEY,   1'b0},
    '{1'b1, 64'd0, MARK_END,  1'b1, 64'd0, KIND_EMPTY, 1'b1},
    '{1'b0, 64'd0, MARK_ELEM, 1'b0, 64'd0, KIND_KEY,   1'b0},
    '{1'b1, 64'd0, MARK_ELEM, 1'b1, 64'd0, KIND_KEY,   1'b0},
    '{1'b0, K_ONES, MARK_LAST, 1'b0, 64'd0, KIND_KEY,  1'b0},
    '{1'b1, K_ONES, MARK_LAST, 1'b1, K_ONES, KIND_KEY, 1'b1},
    '{1'b0, K_ONES, MARK_ODD, 1'b0, 64'd0, KIND_KEY,   1'b0},
    '{1'b1, 64'd5, MARK_LAST, 1'b1, 64'd5, KIND_KEY,   1'b1},
    '{1'b0, 64'd0, MARK_END,  1'b0, 64'd0, KIND_KEY,   1'b0},
    '{1'b0, 64'd9, MARK_ELEM, 1'b0, 64'd0, KIND_KEY,   1'b0},
    '{1'b1, K_MSB, MARK_LAST, 1'b1, K_MSB, KIND_KEY,   1'b1},
    '{1'b1, 64'd3, MARK_ELEM, 1'b0, 64'd0, KIND_KEY,   1'b0},
    '{1'b1, 64'd7, MARK_ELEM, 1'b0, 64'd0, KIND_KEY,   1'b0},
    '{1'b0, 64'd3, MARK_ELEM, 1'b1, 64'd3, KIND_KEY,   1'b0},
    '{1'b0, 64'd9, MARK_LAST, 1'b1, 64'd7, KIND_KEY,   1'b0},
    '{1'b1, 64'd0, MARK_ODD,  1'b1, 64'd9, KIND_KEY,   1'b1}
  };

  initial begin
    res_t typed_r;
    mode_r = MODE_UNION;
    signed_r = 1'b0;
    pend_side = 1'b0;
    ended = '0;
    last_key = '0;
    last_vld = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      send_beat('{side: dir_tab[i].side, key: dir_tab[i].key, mk: dir_tab[i].mk});
      if (dir_tab[i].typed) begin
        typed_r = '{key: dir_tab[i].ekey, kind: dir_tab[i].ekind, fin: dir_tab[i].efin};
        if (step_q.size() == 0) report("directed row", typed_r, '0);
        else if (step_q[step_q.size() - 1] !== typed_r)
          report("directed row", typed_r, step_q[step_q.size() - 1]);
      end
    end
    drain_block();

    // modes 0..7 (5..7 undefined) under both key orders
    for (int ph = 0; ph < 16; ph++) begin
      cfg_write(CFG_SET_MODE, 3'(ph % 8));
      cfg_write(CFG_KEYS_SIGNED, 3'(ph / 8));
      no_idle = (ph % 5 == 2);
      if (ph == 3) stall_req = 1;
      run_op(ph % 3 == 0);
      run_op(1'b0);
      drain_block();
    end
    no_idle = 0;

    if (want_q.size() != 0) report("results left over", want_q[0], '0);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
